### hdl/assert_macros.svh
// Assertion macros for the debounce RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define MTD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("debounce assertion failed");

// Consequent holds in the same cycle as the antecedent
`define MTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debounce assertion failed");

// Consequent holds in the cycle after the antecedent
`define MTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debounce assertion failed");

`endif

### hdl/mtd_pkg.sv
// Types and constants of the multichannel time debounce
package mtd_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int RAW_W            = 8;
    localparam int NOW_W            = 32;
    localparam int DEB_W            = 16;
    localparam int LIM_W            = 5;
    localparam int CH_W             = 4;
    localparam int APB_AW           = 4;
    localparam int APB_DW           = 32;

    // Most reports in one scan
    localparam logic [LIM_W-1:0] MAX_REPORTS = LIM_W'(16);

    // Register indexes (address bits [3:2])
    localparam logic [1:0] REG_ACTIVE_LOW = 2'd0;
    localparam logic [1:0] REG_DWELL_MS   = 2'd1;
    localparam logic [1:0] REG_REPORT_LIM = 2'd2;

    // Register reset values
    localparam logic             RST_ACTIVE_LOW = 1'b1;
    localparam logic [DEB_W-1:0] RST_DWELL_MS   = DEB_W'(50);
    localparam logic [LIM_W-1:0] RST_REPORT_LIM = LIM_W'(16);

    // What one cell receives from its neighbour and the control
    typedef struct packed {
        logic             tok;
        logic             adv;
        logic             seen;
        logic [NOW_W-1:0] now_ms;
        logic [DEB_W-1:0] dwell_ms;
    } t_cell_in;

    // What one cell hands on
    typedef struct packed {
        logic tok;
        logic report;
    } t_cell_out;

endpackage

### hdl/mtd_if.sv
// Valid/ready word interfaces for scans and change reports
interface mtd_in_if;
    import mtd_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_a;
    logic [RAW_W-1:0] raw_b;
    logic             bus_ok;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, raw_a, raw_b, bus_ok, now_ms, input ready);
    modport sink   (input valid, raw_a, raw_b, bus_ok, now_ms, output ready);
endinterface

interface mtd_out_if;
    import mtd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    logic            occupied;
    logic            last;

    modport source (output valid, channel, occupied, last, input ready);
    modport sink   (input valid, channel, occupied, last, output ready);
endinterface

### hdl/mtd_cell.sv
// One channel cell: debounce state and the scan token stage
module mtd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtd_pkg::t_cell_in  i_cell,
    output mtd_pkg::t_cell_out o_cell
);
    import mtd_pkg::*;

    logic             r_tok,     n_tok;
    logic             r_started, n_started;
    logic             r_stable,  n_stable;
    logic             r_cand,    n_cand;
    logic [NOW_W-1:0] r_since,   n_since;
    logic [NOW_W-1:0] elapsed;
    logic             held;
    logic             report;

    // Wrapping elapsed time of the candidate
    assign elapsed = i_cell.now_ms - r_since;
    assign held    = elapsed >= NOW_W'(i_cell.dwell_ms);

    // Update the channel while the token sits here
    always_comb begin
        n_tok     = i_cell.adv ? i_cell.tok : r_tok;
        n_started = r_started;
        n_stable  = r_stable;
        n_cand    = r_cand;
        n_since   = r_since;
        report    = 1'b0;
        if (r_tok) begin
            if (!r_started) begin
                n_started = 1'b1;
                n_stable  = i_cell.seen;
                n_cand    = i_cell.seen;
                n_since   = i_cell.now_ms;
                report    = 1'b1;
            end else if (i_cell.seen != r_cand) begin
                n_cand  = i_cell.seen;
                n_since = i_cell.now_ms;
            end else if (i_cell.seen != r_stable && held) begin
                n_stable = i_cell.seen;
                report   = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok     <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_cell.adv) begin
                r_started <= n_started;
            end
        end
    end

    // Channel payload, committed only when the chain advances
    always_ff @(posedge i_clk) begin
        if (i_cell.adv) begin
            r_stable <= n_stable;
            r_cand   <= n_cand;
            r_since  <= n_since;
        end
    end

    assign o_cell.tok    = r_tok;
    assign o_cell.report = report;

endmodule

### hdl/multichannel_time_debounce.sv
// Top level: APB registers, scan capture, cell chain and report output
//
// Debounces NUM_CHANNELS presence sensors. A scan word with bus_ok set is
// captured and a token walks the chain of channel cells, one cell per clock
// while the chain is not held for a report that has nowhere to go. Ready
// stays low while the token walks and while the scan closes, so a new scan
// is taken only once the last one is through, later while the report output
// is back-pressured. A scan with bus_ok clear is taken and changes nothing.
// Change reports come out in channel order, the final one of a scan flagged
// with last; a report waits in a one-word holding register until the next
// report or the end of the scan decides its last flag. Registers: 0x0
// active_low, 0x4 dwell_ms, 0x8 report_limit; write only while no scan is in
// flight.
module multichannel_time_debounce #(
    parameter int NUM_CHANNELS = mtd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mtd_in_if.sink                     i_in,
    mtd_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mtd_pkg::APB_AW-1:0] paddr,
    input  logic [mtd_pkg::APB_DW-1:0] pwdata,
    output logic [mtd_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import mtd_pkg::*;

`include "assert_macros.svh"

    // Configuration registers
    logic             r_active_low;
    logic [DEB_W-1:0] r_dwell_ms;
    logic [LIM_W-1:0] r_report_lim;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= RST_ACTIVE_LOW;
            r_dwell_ms   <= RST_DWELL_MS;
            r_report_lim <= RST_REPORT_LIM;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ACTIVE_LOW: r_active_low <= pwdata[0];
                REG_DWELL_MS:   r_dwell_ms   <= pwdata[DEB_W-1:0];
                REG_REPORT_LIM: r_report_lim <= pwdata[LIM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        case (paddr[3:2])
            REG_ACTIVE_LOW: prdata = APB_DW'(r_active_low);
            REG_DWELL_MS:   prdata = APB_DW'(r_dwell_ms);
            REG_REPORT_LIM: prdata = APB_DW'(r_report_lim);
            default:        prdata = '0;
        endcase
    end

    // Scan control
    logic                    r_walk, n_walk;
    logic                    r_fin,  n_fin;
    logic [LIM_W-1:0]        r_count, n_count;
    logic [NUM_CHANNELS-1:0] r_seen, n_seen;
    logic [NOW_W-1:0]        r_now;
    logic                    start;
    logic                    adv;
    logic                    walk_end;
    logic [LIM_W-1:0]        lim_eff;

    // Holding and output registers
    logic            r_pend_v, n_pend_v;
    logic [CH_W-1:0] r_pend_ch, n_pend_ch;
    logic            r_pend_occ, n_pend_occ;
    logic            r_out_v, n_out_v;
    logic [CH_W-1:0] r_out_ch, n_out_ch;
    logic            r_out_occ, n_out_occ;
    logic            r_out_last, n_out_last;
    logic            out_free;

    // Cell chain
    t_cell_in                cell_in  [NUM_CHANNELS];
    t_cell_out               cell_out [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] tok_vec;
    logic                    act_rep;
    logic                    act_occ;
    logic [CH_W-1:0]         act_ch;
    logic                    take;

    assign i_in.ready = !r_walk && !r_fin;
    assign start      = i_in.valid && i_in.ready && i_in.bus_ok;
    assign lim_eff    = (r_report_lim > MAX_REPORTS) ? MAX_REPORTS : r_report_lim;
    assign out_free   = !r_out_v || o_out.ready;

    // Map raw levels through the polarity setting
    always_comb begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (k < RAW_W) begin
                n_seen[k] = i_in.raw_a[k % RAW_W] ^ r_active_low;
            end else begin
                n_seen[k] = i_in.raw_b[k % RAW_W] ^ r_active_low;
            end
        end
    end

    // Pick the report of the cell holding the token
    always_comb begin
        act_rep = 1'b0;
        act_occ = 1'b0;
        act_ch  = '0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            tok_vec[k] = cell_out[k].tok;
            if (cell_out[k].tok && cell_out[k].report) begin
                act_rep = 1'b1;
                act_occ = r_seen[k];
                act_ch  = CH_W'(k);
            end
        end
    end

    assign take     = act_rep && (r_count < lim_eff);
    // Hold the chain while a new report has nowhere to go
    assign adv      = start || (r_walk && !(take && r_pend_v && !out_free));
    assign walk_end = r_walk && adv && tok_vec[NUM_CHANNELS-1];

    // Build the chain
    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_in[g].tok = start;
            end else begin : g_link
                assign cell_in[g].tok = cell_out[g-1].tok;
            end
            assign cell_in[g].adv      = adv;
            assign cell_in[g].seen     = r_seen[g];
            assign cell_in[g].now_ms   = r_now;
            assign cell_in[g].dwell_ms = r_dwell_ms;

            mtd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cell  (cell_in[g]),
                .o_cell  (cell_out[g])
            );
        end
    endgenerate

    // Advance scan phases, holding register and output word
    always_comb begin
        n_walk     = r_walk;
        n_fin      = r_fin;
        n_count    = r_count;
        n_pend_v   = r_pend_v;
        n_pend_ch  = r_pend_ch;
        n_pend_occ = r_pend_occ;
        n_out_v    = r_out_v && !o_out.ready;
        n_out_ch   = r_out_ch;
        n_out_occ  = r_out_occ;
        n_out_last = r_out_last;

        if (start) begin
            n_walk  = 1'b1;
            n_count = '0;
        end else if (r_walk && adv) begin
            if (take) begin
                if (r_pend_v) begin
                    n_out_v    = 1'b1;
                    n_out_ch   = r_pend_ch;
                    n_out_occ  = r_pend_occ;
                    n_out_last = 1'b0;
                end
                n_pend_v   = 1'b1;
                n_pend_ch  = act_ch;
                n_pend_occ = act_occ;
                n_count    = r_count + LIM_W'(1);
            end
            if (walk_end) begin
                n_walk = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (r_fin) begin
            if (!r_pend_v) begin
                n_fin = 1'b0;
            end else if (out_free) begin
                n_out_v    = 1'b1;
                n_out_ch   = r_pend_ch;
                n_out_occ  = r_pend_occ;
                n_out_last = 1'b1;
                n_pend_v   = 1'b0;
                n_fin      = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk   <= 1'b0;
            r_fin    <= 1'b0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_walk   <= n_walk;
            r_fin    <= n_fin;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_seen <= n_seen;
            r_now  <= i_in.now_ms;
        end
        r_pend_ch  <= n_pend_ch;
        r_pend_occ <= n_pend_occ;
        r_out_ch   <= n_out_ch;
        r_out_occ  <= n_out_occ;
        r_out_last <= n_out_last;
    end

    assign o_out.valid    = r_out_v;
    assign o_out.channel  = r_out_ch;
    assign o_out.occupied = r_out_occ;
    assign o_out.last     = r_out_last;

    // Checks
    `MTD_ASSERT_ALWAYS(a_tok_single, i_clk, i_rst_n, $onehot0(tok_vec))
    `MTD_ASSERT_IMPL(a_walk_tok, i_clk, i_rst_n, r_walk, tok_vec != '0)
    `MTD_ASSERT_IMPL(a_count_lim, i_clk, i_rst_n, r_walk, r_count <= lim_eff)
    `MTD_ASSERT_NEXT(a_fin_close, i_clk, i_rst_n, r_fin && !r_pend_v, !r_fin)

endmodule
